FILE: rtl/core/zero_run_literal_rle_encoder_defines.svh
// Assertion helpers shared by the encoder RTL.
`ifndef ZERO_RUN_LITERAL_RLE_ENCODER_DEFINES_SVH
`define ZERO_RUN_LITERAL_RLE_ENCODER_DEFINES_SVH

// Checked only out of reset.
`define ZRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked in the cycle after the trigger, out of reset.
`define ZRLE_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/zrle_pkg.sv
package zrle_pkg;

  localparam int unsigned LenW  = 6;
  localparam int unsigned AddrW = LenW + 1;

  localparam logic [LenW-1:0] RunCap    = 6'd63;
  localparam logic [LenW-1:0] MergedCap = 6'd15;
  localparam logic [LenW-1:0] HoldLimit = 6'd8;
  localparam logic [7:0]      ZeroTag   = 8'h40;
  localparam logic [7:0]      MergeTag  = 8'h80;

  // One run close: header byte, literal count (0 for a zero run), store bank.
  typedef struct packed {
    logic [7:0]      hdr;
    logic [LenW-1:0] cnt;
    logic            bank;
  } cmd_t;

  // Literal store write port.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

endpackage

FILE: rtl/core/zero_run_literal_rle_encoder.sv
// Zero-run / literal-run byte encoder. Send a block as data transactions
// (opcode 0) closed by an end transaction (opcode 1); tokens come out one
// byte per cycle while the receiver is ready, with is_header marking run
// headers and last marking the final byte caused by one input transaction.
// The front accepts one input per cycle; it stalls only when a run close
// that emits a command finds the command queue full, or when closing a
// literal run while the previous literal run is still queued or being read
// out of the two-bank literal store (one port each way). The store needs
// no clearing after reset.
module zero_run_literal_rle_encoder #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_header_o,
  output logic       last_o
);

  logic           push, pop, fifo_full, cmd_valid, lit_done;
  zrle_pkg::cmd_t cmd_in, cmd_out;
  zrle_pkg::wr_t  wr;

  zrle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .fifo_full_i (fifo_full),
    .lit_done_i  (lit_done),
    .wr_o        (wr)
  );

  zrle_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  zrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .lit_done_o  (lit_done),
    .wr_i        (wr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_header_o (is_header_o),
    .last_o      (last_o)
  );

endmodule

FILE: rtl/core/zrle_front.sv
`include "zero_run_literal_rle_encoder_defines.svh"

module zrle_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [7:0]           data_byte_i,
  output logic                 push_o,
  output zrle_pkg::cmd_t       cmd_o,
  input  logic                 fifo_full_i,
  input  logic                 lit_done_i,
  output zrle_pkg::wr_t        wr_o
);

  logic                      run_open_q, run_open_d;
  logic                      run_is_zero_q, run_is_zero_d;
  logic [zrle_pkg::LenW-1:0] run_len_q, run_len_d;
  logic [2:0]                held_q, held_d;
  logic                      bank_q, bank_d;
  logic                      lit_busy_q, lit_busy_d;

  logic cur_zero, change, do_close, hold, emit, emit_lit, acc, start, cont;

  assign cur_zero = (data_byte_i == 8'd0);
  assign change   = (cur_zero != run_is_zero_q)
                  || (run_len_q >= zrle_pkg::RunCap)
                  || (!run_is_zero_q && (held_q != 3'd0) && (run_len_q >= zrle_pkg::MergedCap));
  assign do_close = run_open_q && (opcode_i || change);
  assign hold     = do_close && run_is_zero_q && (run_len_q < zrle_pkg::HoldLimit) && !opcode_i;
  assign emit     = do_close && !hold;
  assign emit_lit = do_close && !run_is_zero_q;

  assign in_ready_o = !(emit && fifo_full_i) && !(emit_lit && lit_busy_q);
  assign acc        = in_valid_i && in_ready_o;
  assign start      = acc && !opcode_i && (!run_open_q || change);
  assign cont       = acc && !opcode_i && run_open_q && !change;
  assign push_o     = acc && emit;

  always_comb begin
    if (run_is_zero_q) begin
      cmd_o.hdr = zrle_pkg::ZeroTag | {2'b00, run_len_q};
      cmd_o.cnt = '0;
    end else begin
      if (held_q != 3'd0) begin
        cmd_o.hdr = zrle_pkg::MergeTag | {1'b0, held_q, run_len_q[3:0]};
      end else begin
        cmd_o.hdr = {2'b00, run_len_q};
      end
      cmd_o.cnt = run_len_q;
    end
    cmd_o.bank = bank_q;
  end

  always_comb begin
    run_open_d    = run_open_q;
    run_is_zero_d = run_is_zero_q;
    run_len_d     = run_len_q;
    held_d        = held_q;
    bank_d        = bank_q;
    wr_o.we       = 1'b0;
    wr_o.addr     = {bank_q, run_len_q};
    wr_o.data     = data_byte_i;
    if (acc && do_close) begin
      run_open_d = 1'b0;
      run_len_d  = '0;
      if (hold) begin
        held_d = run_len_q[2:0];
      end else if (emit_lit) begin
        held_d = 3'd0;
      end
    end
    if (start) begin
      run_open_d    = 1'b1;
      run_is_zero_d = cur_zero;
      run_len_d     = 6'd1;
      if (!cur_zero) begin
        bank_d    = !bank_q;
        wr_o.we   = 1'b1;
        wr_o.addr = {!bank_q, 6'd0};
      end
    end else if (cont) begin
      run_len_d = run_len_q + 6'd1;
      wr_o.we   = !run_is_zero_q;
    end
  end

  always_comb begin
    lit_busy_d = lit_busy_q;
    if (push_o && emit_lit) begin
      lit_busy_d = 1'b1;
    end else if (lit_done_i) begin
      lit_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q    <= 1'b0;
      run_is_zero_q <= 1'b0;
      run_len_q     <= '0;
      held_q        <= 3'd0;
      bank_q        <= 1'b0;
      lit_busy_q    <= 1'b0;
    end else begin
      run_open_q    <= run_open_d;
      run_is_zero_q <= run_is_zero_d;
      run_len_q     <= run_len_d;
      held_q        <= held_d;
      bank_q        <= bank_d;
      lit_busy_q    <= lit_busy_d;
    end
  end

  `ZRLE_ASSERT(a_open_len, !run_open_q || (run_len_q != '0), "open run with zero length")
  `ZRLE_ASSERT(a_merged_cap, !(run_open_q && !run_is_zero_q && (held_q != 3'd0)) || (run_len_q <= zrle_pkg::MergedCap), "merged literal run past cap")
  `ZRLE_ASSERT(a_lit_push, !(push_o && (cmd_o.cnt != '0)) || !lit_busy_q, "literal close while bank still draining")

endmodule

FILE: rtl/core/zrle_cmd_fifo.sv
module zrle_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zrle_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output zrle_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  zrle_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/zrle_back.sv
`include "zero_run_literal_rle_encoder_defines.svh"

module zrle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  zrle_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           lit_done_o,
  input  zrle_pkg::wr_t  wr_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           is_header_o,
  output logic           last_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StLit  = 1'b1;

  logic                       st_q, st_d;
  logic [zrle_pkg::LenW-1:0]  idx_q, idx_d, cnt_q, cnt_d;
  logic                       bank_q, bank_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       is_header_q, is_header_d;
  logic                       last_q, last_d;
  logic [7:0]                 mem_q [2**zrle_pkg::AddrW];
  logic [7:0]                 rdata_q;
  logic                       adv, lit_last;

  assign adv      = !out_valid_q || out_ready_i;
  assign lit_last = ((idx_q + 6'd1) == cnt_q);
  assign pop_o    = adv && (st_q == StIdle) && cmd_valid_i;

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    bank_d      = bank_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    is_header_d = is_header_q;
    last_d      = last_q;
    lit_done_o  = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (pop_o) begin
          out_valid_d = 1'b1;
          out_byte_d  = cmd_i.hdr;
          is_header_d = 1'b1;
          last_d      = (cmd_i.cnt == '0);
          idx_d       = '0;
          cnt_d       = cmd_i.cnt;
          bank_d      = cmd_i.bank;
          if (cmd_i.cnt != '0) begin
            st_d = StLit;
          end
        end
      end
      StLit: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          is_header_d = 1'b0;
          last_d      = lit_last;
          if (lit_last) begin
            st_d       = StIdle;
            lit_done_o = 1'b1;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[{bank_d, idx_d}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    bank_q      <= bank_d;
    out_byte_q  <= out_byte_d;
    is_header_q <= is_header_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_header_o = is_header_q;
  assign last_o      = last_q;

  `ZRLE_ASSERT(a_idx_range, (st_q != StLit) || (idx_q < cnt_q), "literal index past run length")
  `ZRLE_ASSERT_NEXT(a_done_idle, lit_done_o, (st_q == StIdle) && out_valid_q && last_q, "readout end not flagged")
  `ZRLE_ASSERT_NEXT(a_pop_hdr, pop_o, out_valid_q && is_header_q, "command pop without header")

endmodule

FILE: tb/zrle_checker.sv
package zrle_tb_pkg;

  typedef enum logic {
    OpData = 1'b0,
    OpEnd  = 1'b1
  } zrle_op_e;

endpackage

module zrle_checker
  import zrle_pkg::*;
  import zrle_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              opcode_i,
  input  logic [7:0]        data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        out_byte_i,
  input  logic              is_header_i,
  input  logic              last_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] val;
    logic       hdr;
    logic       lst;
  } token_t;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  logic            run_open = 1'b0;
  logic            run_is_zero = 1'b0;
  logic [LenW-1:0] run_len = '0;
  logic [2:0]      held_zeros = '0;
  logic [7:0]      lit_store[0:62];
  int unsigned     n_errors = 0;

  task automatic push_token(input logic [7:0] v, input logic hdr);
    token_t t;
    t.val = v;
    t.hdr = hdr;
    t.lst = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic close_run(input logic at_end);
    if (run_is_zero) begin
      if (run_len < HoldLimit && !at_end) begin
        held_zeros = run_len[2:0];
      end else begin
        push_token(ZeroTag | {2'b00, run_len}, 1'b1);
      end
    end else begin
      if (held_zeros != 0) begin
        push_token(MergeTag | {1'b0, held_zeros, 4'b0000} | {4'b0000, run_len[3:0]}, 1'b1);
        held_zeros = '0;
      end else begin
        push_token({2'b00, run_len}, 1'b1);
      end
      for (int i = 0; i < int'(run_len); i++) begin
        push_token(lit_store[i], 1'b0);
      end
    end
    run_len  = '0;
    run_open = 1'b0;
  endtask

  task automatic open_run(input logic [7:0] b);
    run_open    = 1'b1;
    run_is_zero = (b == 8'h00);
    run_len     = 6'd1;
    if (b != 8'h00) begin
      lit_store[0] = b;
    end
  endtask

  task automatic predict_tokens(input logic op, input logic [7:0] b);
    logic cur_zero;
    logic change;
    token_t t;
    step_tokens.delete();
    if (op == OpEnd) begin
      if (run_open) begin
        close_run(1'b1);
      end
    end else if (!run_open) begin
      open_run(b);
    end else begin
      cur_zero = (b == 8'h00);
      change = (cur_zero != run_is_zero) || (run_len >= RunCap) ||
               (!run_is_zero && held_zeros != 0 && run_len >= MergedCap);
      if (change) begin
        close_run(1'b0);
        open_run(b);
      end else begin
        if (!run_is_zero) begin
          lit_store[run_len] = b;
        end
        run_len = run_len + 6'd1;
      end
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t = step_tokens[i];
      t.lst = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  always @(posedge clk_i) begin
    token_t exp_tok;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        predict_tokens(opcode_i, data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected transaction, expected none, actual byte %02h hdr %0b last %0b",
                   $time, out_byte_i, is_header_i, last_i);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (exp_tok.val !== out_byte_i) begin
            n_errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_tok.val, out_byte_i);
          end
          if (exp_tok.hdr !== is_header_i) begin
            n_errors++;
            $display("%0t: is_header expected %0b actual %0b", $time, exp_tok.hdr, is_header_i);
          end
          if (exp_tok.lst !== last_i) begin
            n_errors++;
            $display("%0t: last expected %0b actual %0b", $time, exp_tok.lst, last_i);
          end
        end
      end
    end
    pending_o <= expected_tokens.size();
    errors_o  <= n_errors;
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;

  import zrle_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = OpData;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       is_header;
  logic       last;

  int unsigned pending;
  int unsigned n_errors;
  int unsigned n_sent = 0;
  logic        calm = 1'b0;

  always #2 clk_i = ~clk_i;

  zero_run_literal_rle_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .is_header_o (is_header),
    .last_o      (last)
  );

  zrle_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .opcode_i    (opcode),
    .data_byte_i (data_byte),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_byte_i  (out_byte),
    .is_header_i (is_header),
    .last_i      (last),
    .pending_o   (pending),
    .errors_o    (n_errors)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_run(input logic zeros, input int len);
    for (int i = 0; i < len; i++) begin
      send_item(OpData, zeros ? 8'h00 : 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic int zero_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 7);
    if (r < 9) return $urandom_range(8, 20);
    return $urandom_range(55, 70);
  endfunction

  function automatic int lit_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 15);
    if (r < 17) return $urandom_range(16, 30);
    return $urandom_range(55, 70);
  endfunction

  // receiver: random stalls, one long hold-off to back up the block
  initial begin
    int k;
    k = 0;
    @(posedge clk_i);
    forever begin
      k++;
      if (k == 30) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (pick_gap() > 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic zeros;
    int   nruns;
    bit   drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // end with nothing open, data ignored
    send_item(OpEnd, 8'hff);
    // short zero run merged into literal header
    send_item(OpData, 8'h00);
    send_item(OpData, 8'h00);
    send_item(OpData, 8'h01);
    send_item(OpData, 8'hff);
    send_item(OpEnd, 8'h00);
    // zero run at block end
    send_item(OpData, 8'h00);
    send_item(OpData, 8'h00);
    send_item(OpData, 8'h00);
    send_item(OpEnd, 8'h5a);
    // zero run of 8 is not held
    send_item(OpData, 8'h7f);
    send_run(1'b1, 8);
    send_item(OpData, 8'h80);
    send_item(OpEnd, 8'haa);
    send_item(OpEnd, 8'h55);
    wait_drained();

    // caps: literal 63, zero 63, merged literal 15
    send_run(1'b0, 70);
    send_run(1'b1, 66);
    send_run(1'b1, 3);
    send_run(1'b0, 20);
    send_item(OpEnd, 8'($urandom_range(0, 255)));

    while (n_sent < 360) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < 85) begin
        nruns = $urandom_range(1, 6);
        zeros = 1'($urandom_range(0, 1));
        for (int r = 0; r < nruns; r++) begin
          send_run(zeros, zeros ? zero_len() : lit_len());
          zeros = ~zeros;
        end
        send_item(OpEnd, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(($urandom_range(0, 3) == 0) ? OpEnd : OpData,
                    $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
      end
      if (!drained_mid && n_sent > 250) begin
        drained_mid = 1'b1;
        wait_drained();
      end
    end
    send_item(OpEnd, 8'h00);
    calm = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/zrle_pkg.sv
rtl/core/zrle_front.sv
rtl/core/zrle_cmd_fifo.sv
rtl/core/zrle_back.sv
rtl/core/zero_run_literal_rle_encoder.sv
tb/zrle_checker.sv
tb/tb_top.sv
